[design/dter_pkg.sv]
`timescale 1ns / 1ps
package dter_pkg;

  localparam int NumLines = 4;
  localparam int CodeW = 21;
  localparam int RunW = 5;
  localparam int LenW = 6;
  localparam int PeriodW = 16;
  localparam int QuoW = 20;
  localparam int RemW = PeriodW + 1;
  localparam int CntW = 5;

  localparam logic [RunW-1:0] RunMax = 5'd31;
  localparam logic [LenW-1:0] LenMax = 6'd63;
  localparam logic [QuoW-1:0] ErpmScale = 20'd1000000;
  localparam logic [15:0] ErpmMax = 16'hFFFF;
  localparam logic [3:0] SpbReset = 4'd4;
  localparam logic [3:0] SpbMin = 4'd2;
  localparam logic [3:0] SpbMax = 4'd8;
  localparam logic [CntW-1:0] DivLast = 5'd19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_DECODE,
    ST_DIV,
    ST_OUT
  } state_t;

  // {invalid, nibble}
  function automatic logic [4:0] gcr_decode(input logic [4:0] q);
    logic [4:0] r;
    case (q)
      5'h09: r = 5'h09;
      5'h0A: r = 5'h0A;
      5'h0B: r = 5'h0B;
      5'h0D: r = 5'h0D;
      5'h0E: r = 5'h0E;
      5'h0F: r = 5'h0F;
      5'h12: r = 5'h02;
      5'h13: r = 5'h03;
      5'h15: r = 5'h05;
      5'h16: r = 5'h06;
      5'h17: r = 5'h07;
      5'h19: r = 5'h00;
      5'h1A: r = 5'h08;
      5'h1B: r = 5'h01;
      5'h1D: r = 5'h04;
      5'h1E: r = 5'h0C;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

endpackage

[design/dshot_telemetry_erpm_decoder.sv]
`timescale 1ns / 1ps
// Channel | Signals                                    | Transfer when
// input   | in_valid in_ready line_bits last_sample    | in_valid & in_ready
// output  | out_valid out_ready channel erpm           | out_valid & out_ready
//         |   frame_error last_result                  |
// config  | cfg_we cfg_data                            | cfg_we
//
// Once two samples of the window have been seen, each further sample also passes
// through the shared run/shift step, one line at a time.
// A last sample then gives four results; each passes through a decode step and the
// bit-serial restoring divider (skipped on error), then waits for out_ready.
// in_ready is low while a sample or a result is in progress.
// Synchronous reset sets samples_per_bit to 4 and clears the window state.
module dshot_telemetry_erpm_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] line_bits,
  input  logic       last_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] channel,
  output logic [15:0] erpm,
  output logic       frame_error,
  output logic       last_result,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  dter_pkg::state_t state, state_next;

  logic [3:0] spb;
  logic [3:0] older, newer, filt;
  logic [1:0] seen;
  logic       last_pend;
  logic [1:0] k;
  logic                          lvl [dter_pkg::NumLines];
  logic [dter_pkg::RunW-1:0]     run [dter_pkg::NumLines];
  logic [dter_pkg::LenW-1:0]     blen [dter_pkg::NumLines];
  logic [dter_pkg::CodeW-1:0]    code [dter_pkg::NumLines];
  logic [dter_pkg::PeriodW-1:0]  period;
  logic                          err;
  logic [dter_pkg::QuoW-1:0]     dvd, quo, quo_next;
  logic [dter_pkg::RemW-1:0]     rem, rem_next, rem_shift;
  logic [dter_pkg::CntW-1:0]     cnt;
  logic [15:0]                   erpm_r;

  logic in_xfer, out_xfer, k_last;
  assign in_xfer = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign k_last = (k == 2'(dter_pkg::NumLines - 1));

  // Run/shift step for line k
  logic [3:0] spb_c;
  logic [4:0] th3, th2, cnt_run;
  logic [1:0] nbits;
  logic [2:0] fill;
  logic [6:0] len_sum;
  logic       bitv, prv;
  logic [dter_pkg::CodeW-1:0] code_step;

  always_comb begin
    spb_c = spb;
    if (spb < dter_pkg::SpbMin) spb_c = dter_pkg::SpbMin;
    if (spb > dter_pkg::SpbMax) spb_c = dter_pkg::SpbMax;
    th3 = {1'b0, spb_c} * 5'd3 - 5'd2;
    th2 = {spb_c, 1'b0} - 5'd2;
    bitv = filt[k];
    prv = lvl[k];
    cnt_run = (blen[k] != '0) ? run[k] : '0;
    if (cnt_run >= th3) nbits = 2'd3;
    else if (cnt_run >= th2) nbits = 2'd2;
    else nbits = 2'd1;
    fill = prv ? 3'b111 : 3'b000;
    len_sum = {1'b0, blen[k]} + {5'b0, nbits};
    case (nbits)
      2'd2: code_step = {code[k][18:0], fill[1:0]};
      2'd3: code_step = {code[k][17:0], fill};
      default: code_step = {code[k][19:0], fill[0]};
    endcase
  end

  // Decode of line k
  logic [dter_pkg::CodeW-1:0] pad, gray;
  logic [4:0] q0, q1, q2, q3;
  logic [3:0] crc;
  logic [11:0] data;
  logic [dter_pkg::PeriodW-1:0] p_dec;
  logic bad;

  always_comb begin
    if (blen[k] == 6'd21) pad = {code[k][19:0], 1'b1};
    else if (blen[k] == 6'd20) pad = {code[k][18:0], 2'b11};
    else pad = code[k];
    gray = pad ^ (pad >> 1);
    q0 = dter_pkg::gcr_decode(gray[4:0]);
    q1 = dter_pkg::gcr_decode(gray[9:5]);
    q2 = dter_pkg::gcr_decode(gray[14:10]);
    q3 = dter_pkg::gcr_decode(gray[19:15]);
    crc = ~(q1[3:0] ^ q2[3:0] ^ q3[3:0]);
    data = {q3[3:0], q2[3:0], q1[3:0]};
    p_dec = {7'b0, data[8:0]} << data[11:9];
    bad = q0[4] || q1[4] || q2[4] || q3[4] || (crc != q0[3:0]) || (p_dec == '0);
  end

  // Restoring divider step
  always_comb begin
    rem_shift = {rem[dter_pkg::RemW-2:0], dvd[dter_pkg::QuoW-1]};
    if (rem_shift >= {1'b0, period}) begin
      rem_next = rem_shift - {1'b0, period};
      quo_next = {quo[dter_pkg::QuoW-2:0], 1'b1};
    end else begin
      rem_next = rem_shift;
      quo_next = {quo[dter_pkg::QuoW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dter_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (seen >= 2'd2) state_next = dter_pkg::ST_LINE;
          else if (last_sample) state_next = dter_pkg::ST_DECODE;
        end
      end
      dter_pkg::ST_LINE: begin
        if (k_last) state_next = last_pend ? dter_pkg::ST_DECODE : dter_pkg::ST_IDLE;
      end
      dter_pkg::ST_DECODE: state_next = bad ? dter_pkg::ST_OUT : dter_pkg::ST_DIV;
      dter_pkg::ST_DIV: if (cnt == dter_pkg::DivLast) state_next = dter_pkg::ST_OUT;
      dter_pkg::ST_OUT: begin
        if (out_ready) state_next = k_last ? dter_pkg::ST_IDLE : dter_pkg::ST_DECODE;
      end
      default: state_next = dter_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == dter_pkg::ST_IDLE);
    out_valid = (state == dter_pkg::ST_OUT);
    channel = k;
    erpm = erpm_r;
    frame_error = err;
    last_result = k_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dter_pkg::ST_IDLE;
      spb <= dter_pkg::SpbReset;
      older <= '1;
      newer <= '1;
      seen <= '0;
      last_pend <= 1'b0;
      k <= '0;
      for (int i = 0; i < dter_pkg::NumLines; i++) begin
        lvl[i] <= 1'b1;
        run[i] <= '0;
        blen[i] <= '0;
        code[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) spb <= cfg_data;
      case (state)
        dter_pkg::ST_IDLE: begin
          if (in_xfer) begin
            filt <= (older & newer) | (newer & line_bits) | (older & line_bits);
            if (seen < 2'd2) seen <= seen + 2'd1;
            older <= newer;
            newer <= line_bits;
            last_pend <= last_sample;
            k <= '0;
          end
        end
        dter_pkg::ST_LINE: begin
          if (bitv != prv) begin
            code[k] <= code_step;
            blen[k] <= (len_sum > {1'b0, dter_pkg::LenMax}) ? dter_pkg::LenMax
                                                          : len_sum[dter_pkg::LenW-1:0];
            lvl[k] <= bitv;
            run[k] <= '0;
          end else if (run[k] < dter_pkg::RunMax) begin
            run[k] <= run[k] + 5'd1;
          end
          k <= k + 2'd1;
        end
        dter_pkg::ST_DECODE: begin
          period <= p_dec;
          err <= bad;
          erpm_r <= '0;
          dvd <= dter_pkg::ErpmScale;
          rem <= '0;
          quo <= '0;
          cnt <= '0;
        end
        dter_pkg::ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          dvd <= {dvd[dter_pkg::QuoW-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == dter_pkg::DivLast) begin
            erpm_r <= (quo_next[dter_pkg::QuoW-1:16] != '0) ? dter_pkg::ErpmMax
                                                            : quo_next[15:0];
          end
        end
        dter_pkg::ST_OUT: begin
          if (out_ready) begin
            k <= k + 2'd1;
            if (k_last) begin
              // close the window
              older <= '1;
              newer <= '1;
              seen <= '0;
              last_pend <= 1'b0;
              for (int i = 0; i < dter_pkg::NumLines; i++) begin
                lvl[i] <= 1'b1;
                run[i] <= '0;
                blen[i] <= '0;
                code[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/dter_checker.sv]
`timescale 1ns / 1ps
module dter_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  channel,
  input logic [15:0] erpm,
  input logic        frame_error,
  input logic        last_result
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while a result is pending");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (erpm == 16'd0)) else $error("erpm nonzero on error");

  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_result == (channel == 2'd3))) else $error("last_result mismatch");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_result) |=> !in_ready)
    else $error("input reopened before the final result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(channel) && $stable(erpm)))
    else $error("result changed while stalled");

endmodule

bind dshot_telemetry_erpm_decoder dter_checker u_dter_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .channel(channel),
  .erpm(erpm),
  .frame_error(frame_error),
  .last_result(last_result)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  typedef bit bool_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  line_bits = 4'hF;
  logic        last_sample = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  channel;
  logic [15:0] erpm;
  logic        frame_error;
  logic        last_result;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_data = 4'd0;

  dshot_telemetry_erpm_decoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .line_bits(line_bits), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel(channel), .erpm(erpm), .frame_error(frame_error),
    .last_result(last_result),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  chan;
    logic [15:0] rate;
    logic        err;
    logic        fin;
  } telem_t;

  typedef struct {
    logic [3:0] bits;
    logic       fin;
    logic       typed;
    telem_t     want;
  } row_t;

  // predictor state
  logic [3:0]  spb_q;
  logic [3:0]  prev2, prev1;
  int          seen;
  logic        lvl [4];
  int          runc [4];
  int          blen [4];
  logic [20:0] code [4];

  telem_t erpm_q[$];
  int     errors = 0;
  int     n_results = 0;
  int     n_bad = 0;
  int     n_items = 0;
  bool_t  hold_sink;

  function automatic logic [4:0] quintet(input logic [4:0] q);
    logic [4:0] r;
    case (q)
      5'h09: r = 5'h09; 5'h0A: r = 5'h0A; 5'h0B: r = 5'h0B;
      5'h0D: r = 5'h0D; 5'h0E: r = 5'h0E; 5'h0F: r = 5'h0F;
      5'h12: r = 5'h02; 5'h13: r = 5'h03; 5'h15: r = 5'h05;
      5'h16: r = 5'h06; 5'h17: r = 5'h07; 5'h19: r = 5'h00;
      5'h1A: r = 5'h08; 5'h1B: r = 5'h01; 5'h1D: r = 5'h04;
      5'h1E: r = 5'h0C;
      default: r = 5'h10;
    endcase
    return r;
  endfunction

  task automatic clear_window();
    prev2 = 4'hF;
    prev1 = 4'hF;
    seen = 0;
    for (int k = 0; k < 4; k++) begin
      lvl[k] = 1'b1;
      runc[k] = 0;
      blen[k] = 0;
      code[k] = '0;
    end
  endtask

  function automatic telem_t decode_line(input int k);
    telem_t r;
    logic [21:0] c;
    logic [4:0] q0, q1, q2, q3;
    logic [11:0] data;
    int unsigned p;
    c = {1'b0, code[k]};
    if (blen[k] == 21) c = {c[20:0], 1'b1};
    else if (blen[k] == 20) c = {c[19:0], 2'b11};
    c[21] = 1'b0;
    c = c ^ (c >> 1);
    q0 = quintet(c[4:0]);
    q1 = quintet(c[9:5]);
    q2 = quintet(c[14:10]);
    q3 = quintet(c[19:15]);
    r.chan = k[1:0];
    r.fin = (k == 3);
    r.rate = '0;
    r.err = 1'b1;
    if (q0[4] | q1[4] | q2[4] | q3[4]) return r;
    if ((~(q1[3:0] ^ q2[3:0] ^ q3[3:0])) != q0[3:0]) return r;
    data = {q3[3:0], q2[3:0], q1[3:0]};
    p = data[8:0] << data[11:9];
    if (p == 0) return r;
    p = 1000000 / p;
    r.rate = (p > 65535) ? 16'hFFFF : p[15:0];
    r.err = 1'b0;
    return r;
  endfunction

  task automatic predict_sample(input logic [3:0] cur, input logic fin);
    logic [3:0] f;
    int s, th3, th2, cnt, n;
    if (seen >= 2) begin
      f = (prev2 & prev1) | (prev1 & cur) | (prev2 & cur);
      s = spb_q < 2 ? 2 : (spb_q > 8 ? 8 : spb_q);
      th3 = 3 * s - 2;
      th2 = 2 * s - 2;
      for (int k = 0; k < 4; k++) begin
        if (f[k] != lvl[k]) begin
          cnt = blen[k] != 0 ? runc[k] : 0;
          n = cnt >= th3 ? 3 : (cnt >= th2 ? 2 : 1);
          code[k] = 21'((code[k] << n) | (lvl[k] ? ((1 << n) - 1) : 0));
          blen[k] = blen[k] + n > 63 ? 63 : blen[k] + n;
          lvl[k] = f[k];
          runc[k] = 0;
        end else if (runc[k] < 31) begin
          runc[k]++;
        end
      end
    end else begin
      seen++;
    end
    prev2 = prev1;
    prev1 = cur;
    if (fin) begin
      for (int k = 0; k < 4; k++) erpm_q.push_back(decode_line(k));
      clear_window();
    end
  endtask

  // scoreboard
  always @(posedge clk) begin
    telem_t w;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (erpm_q.size() == 0) begin
        $error("result with nothing expected: channel %0d", channel);
        errors++;
      end else begin
        w = erpm_q.pop_front();
        if (frame_error) n_bad++;
        if (channel !== w.chan) begin
          $error("channel exp %0d got %0d", w.chan, channel); errors++;
        end
        if (erpm !== w.rate) begin
          $error("erpm exp %0d got %0d", w.rate, erpm); errors++;
        end
        if (frame_error !== w.err) begin
          $error("frame_error exp %0b got %0b", w.err, frame_error); errors++;
        end
        if (last_result !== w.fin) begin
          $error("last_result exp %0b got %0b", w.fin, last_result); errors++;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      out_ready <= (gap == 0);
      if (gap != 0) begin
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  // valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send(input logic [3:0] b, input logic fin);
    int gap;
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_bits <= b;
    last_sample <= fin;
    do @(posedge clk); while (!in_ready);
    predict_sample(b, fin);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (erpm_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_spb(input logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    spb_q = v;
  endtask

  // send one encoded frame: 16-bit payload -> GCR -> map -> oversampled
  task automatic send_frame(input logic [11:0] data, input bit good_crc,
                            input int spb, input int jitter);
    logic [4:0] enc [16];
    logic [3:0] nib [4];
    logic [19:0] g;
    logic [20:0] line;
    int lv;
    enc = '{5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
            5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F};
    nib[3] = data[11:8];
    nib[2] = data[7:4];
    nib[1] = data[3:0];
    nib[0] = ~(nib[1] ^ nib[2] ^ nib[3]);
    if (!good_crc) nib[0] = nib[0] ^ 4'h1;
    g = {enc[nib[3]], enc[nib[2]], enc[nib[1]], enc[nib[0]]};
    // line level: prefix-xor of the GCR bits, preceded by a low start bit
    lv = 0;
    line[20] = 1'b0;
    for (int i = 19; i >= 0; i--) begin
      lv = lv ^ g[i];
      line[i] = lv[0] ^ 1'b0;
    end
    // idle high, then the frame, then idle high
    repeat (2) send(4'hF | 4'($urandom_range(0, 15)), 1'b0);
    for (int i = 20; i >= 0; i--) begin
      for (int s = 0; s < spb + ((jitter != 0 && $urandom_range(0, 3) == 0) ? 1 : 0); s++)
        send(line[i] ? 4'hF : 4'h0, 1'b0);
    end
    repeat (spb * 3) send(4'hF, 1'b0);
    send(4'hF, 1'b1);
  endtask

  row_t dir_rows [$];

  initial begin
    int spb;
    spb_q = dter_pkg::SpbReset;
    clear_window();
    hold_sink = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    dir_rows.push_back('{4'hF, 1'b1, 1'b1, '{2'd0, 16'd0, 1'b1, 1'b0}});
    dir_rows.push_back('{4'h0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{4'hF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'hA, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h5, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'hF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'hF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'h3, 1'b0, 1'b0, '0});
    dir_rows.push_back('{4'hC, 1'b1, 1'b0, '0});
    foreach (dir_rows[i]) begin
      // a window of idle-high samples gives an empty code: error on every line
      if (dir_rows[i].typed && erpm_q.size() == 0) begin
        send(dir_rows[i].bits, dir_rows[i].fin);
        if (erpm_q[0] !== dir_rows[i].want)
          begin $error("directed row %0d predictor disagrees", i); errors++; end
      end else begin
        send(dir_rows[i].bits, dir_rows[i].fin);
      end
    end
    drain();

    // several oversampling settings, extremes included; whole frames only
    // where the window stays short
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: spb = 8;
        1: spb = 15;
        2: spb = 4;
        3: spb = 3;
        4: spb = 0;
        default: spb = 2;
      endcase
      drain();
      write_spb(4'(spb));
      if (spb <= 3) begin
        send_frame((ph == 4) ? 12'h001 : 12'($urandom_range(0, 4095)),
                   (ph == 4) || ($urandom_range(0, 4) != 0),
                   spb < 2 ? 2 : spb, ph & 1);
      end
      if (ph == 3) hold_sink = 1'b1;
      // noise window
      repeat ($urandom_range(0, 8)) send(4'($urandom_range(0, 15)), 1'b0);
      send(4'($urandom_range(0, 15)), 1'b1);
    end
    drain();
    $display("Sent %0d samples; checked %0d telemetry results (%0d with frame errors).",
             n_items, n_results, n_bad);
    $display("Frames at oversampling 0, 2 and 3, noise at 4, 8 and 15, one long output stall.");
    if (errors == 0 && erpm_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
